[rtl/homogeneous_vertex_transform_macros.svh]
// Assertion macros for the homogeneous vertex transform checker.
// No dependencies; expects clk and rst in the scope where a macro is used.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH

// same-cycle implication
`define HVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hvt check failed");

// next-cycle implication
`define HVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hvt check failed");

`endif

[rtl/hvt_pkg.sv]
// Shared constants and types for the homogeneous vertex transform.
// No dependencies.
package hvt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ELEM_W          = 32;   // matrix element, signed
  localparam int REG_W           = 64;   // one config register, two elements
  localparam int CFG_IDX_W       = 3;
  localparam int ROOT_W          = 32;   // floor(sqrt) of a 64-bit radicand
  localparam int MAG_W           = 32;   // normalised magnitude, <= 2^31

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_B = 3'd5;

  // identity matrix
  localparam logic [REG_W-1:0] RST_ROW0_A = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW0_B = 64'h0;
  localparam logic [REG_W-1:0] RST_ROW1_A = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW1_B = 64'h0;
  localparam logic [REG_W-1:0] RST_ROW2_A = 64'h0;
  localparam logic [REG_W-1:0] RST_ROW2_B = 64'h0001_0000_0000_0000;

  // pipeline flow control handed to the sub-pipelines
  typedef struct packed {
    logic en;
    logic valid;
  } hvt_flow_t;

endpackage

[rtl/hvt_sqrt.sv]
// Pipelined integer square root, two result bits per stage, with sideband.
// Depends on hvt_pkg.
module hvt_sqrt #(
  parameter int SB = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  hvt_pkg::hvt_flow_t        flow,
  input  logic [63:0]               rad,
  input  logic [SB-1:0]             side_in,
  output logic                      valid_out,
  output logic [hvt_pkg::ROOT_W-1:0] root,
  output logic [SB-1:0]             side_out
);
  import hvt_pkg::*;

  localparam int NS = 16;

  logic [NS-1:0]   v_q;
  logic [63:0]     s_q    [NS];
  logic [63:0]     r_q    [NS];
  logic [SB-1:0]   side_q [NS];
  logic [63:0]     s_src  [NS];
  logic [63:0]     r_src  [NS];
  logic [SB-1:0]   side_src [NS];
  logic [63:0]     s_next [NS];
  logic [63:0]     r_next [NS];

  always_comb begin
    logic [63:0] s_t;
    logic [63:0] r_t;
    logic [63:0] b_t;
    s_src[0]    = rad;
    r_src[0]    = '0;
    side_src[0] = side_in;
    for (int k = 1; k < NS; k++) begin
      s_src[k]    = s_q[k-1];
      r_src[k]    = r_q[k-1];
      side_src[k] = side_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      s_t = s_src[k];
      r_t = r_src[k];
      for (int t = 0; t < 2; t++) begin
        b_t = 64'd1 << (62 - 2 * (2 * k + t));
        if (s_t >= r_t + b_t) begin
          s_t = s_t - (r_t + b_t);
          r_t = (r_t >> 1) + b_t;
        end else begin
          r_t = r_t >> 1;
        end
      end
      s_next[k] = s_t;
      r_next[k] = r_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (flow.en) begin
      v_q <= {v_q[NS-2:0], flow.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en) begin
      for (int k = 0; k < NS; k++) begin
        s_q[k]    <= s_next[k];
        r_q[k]    <= r_next[k];
        side_q[k] <= side_src[k];
      end
    end
  end

  assign valid_out = v_q[NS-1];
  assign root      = r_q[NS-1][ROOT_W-1:0];
  assign side_out  = side_q[NS-1];

endmodule

[rtl/hvt_div.sv]
// Three-lane pipelined rounding divider, two quotient bits per stage.
// Depends on hvt_pkg.
module hvt_div #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF,
  parameter int SB        = 1,
  localparam int DS       = (FRAC_BITS + 2) / 2,
  localparam int QE       = 2 * DS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hvt_pkg::hvt_flow_t            flow,
  input  logic [2:0][hvt_pkg::MAG_W-1:0] mag,
  input  logic [hvt_pkg::ROOT_W-1:0]    den,
  input  logic [SB-1:0]                 side_in,
  output logic                          valid_out,
  output logic [2:0][QE-1:0]            quo,
  output logic [SB-1:0]                 side_out
);
  import hvt_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS + 1;
  localparam int RW = ROOT_W + 1;

  logic [DS-1:0]        v_q;
  logic [2:0][RW-1:0]   rem_q  [DS];
  logic [2:0][QE-1:0]   low_q  [DS];
  logic [2:0][QE-1:0]   quo_q  [DS];
  logic [ROOT_W-1:0]    den_q  [DS];
  logic [SB-1:0]        side_q [DS];

  logic [2:0][RW-1:0]   rem_src [DS];
  logic [2:0][QE-1:0]   low_src [DS];
  logic [2:0][QE-1:0]   quo_src [DS];
  logic [ROOT_W-1:0]    den_src [DS];
  logic [SB-1:0]        side_src [DS];
  logic [2:0][RW-1:0]   rem_next [DS];
  logic [2:0][QE-1:0]   low_next [DS];
  logic [2:0][QE-1:0]   quo_next [DS];

  always_comb begin
    logic [NW-1:0] n_t;
    logic [RW:0]   t_t;
    logic [RW-1:0] r_t;
    logic [QE-1:0] l_t;
    logic [QE-1:0] q_t;
    // numerator carries half the divisor for round-to-nearest
    for (int l = 0; l < 3; l++) begin
      n_t = (NW'(mag[l]) << FRAC_BITS) + NW'(den >> 1);
      rem_src[0][l] = RW'(n_t >> QE);
      low_src[0][l] = n_t[QE-1:0];
      quo_src[0][l] = '0;
    end
    den_src[0]  = den;
    side_src[0] = side_in;
    for (int k = 1; k < DS; k++) begin
      rem_src[k]  = rem_q[k-1];
      low_src[k]  = low_q[k-1];
      quo_src[k]  = quo_q[k-1];
      den_src[k]  = den_q[k-1];
      side_src[k] = side_q[k-1];
    end
    for (int k = 0; k < DS; k++) begin
      for (int l = 0; l < 3; l++) begin
        r_t = rem_src[k][l];
        l_t = low_src[k][l];
        q_t = quo_src[k][l];
        for (int t = 0; t < 2; t++) begin
          t_t = {r_t, l_t[QE-1]};
          l_t = l_t << 1;
          if (t_t >= (RW + 1)'(den_src[k])) begin
            r_t = RW'(t_t - (RW + 1)'(den_src[k]));
            q_t = {q_t[QE-2:0], 1'b1};
          end else begin
            r_t = t_t[RW-1:0];
            q_t = {q_t[QE-2:0], 1'b0};
          end
        end
        rem_next[k][l] = r_t;
        low_next[k][l] = l_t;
        quo_next[k][l] = q_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (flow.en) begin
      if (DS > 1) begin
        v_q <= {v_q[DS-2:0], flow.valid};
      end else begin
        v_q[0] <= flow.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en) begin
      for (int k = 0; k < DS; k++) begin
        rem_q[k]  <= rem_next[k];
        low_q[k]  <= low_next[k];
        quo_q[k]  <= quo_next[k];
        den_q[k]  <= den_src[k];
        side_q[k] <= side_src[k];
      end
    end
  end

  assign valid_out = v_q[DS-1];
  assign quo       = quo_q[DS-1];
  assign side_out  = side_q[DS-1];

endmodule

[rtl/homogeneous_vertex_transform.sv]
// Homogeneous vertex transform: top level with matrix registers and pipeline.
// Depends on hvt_pkg, hvt_sqrt and hvt_div.
//
// Usage
//   s_axis_*: one vertex or direction per transaction. tdata holds x, y, z, w
//   (signed fixed point), tuser is is_point. m_axis_*: one result per input,
//   in order. tdata holds x, y, z; tuser holds out_w, zero_length, saturated.
//   cfg_*: writes one 64-bit matrix register per transaction; always ready.
//   Write the matrix only while no transaction is in flight.
// Pipeline: six arithmetic stages, sixteen stages of square root and the
//   divider stages, then the output register.
// Throughput: one transaction per clock while the pipeline is not frozen;
//   every stage is registered, the widest step is one 32 x COORD_WIDTH
//   multiply per matrix element.
// Stall: when m_axis_tready is low the output register holds its result and
//   the pipeline keeps moving until one more result lands in the skid
//   register; only then is s_axis_tready dropped and the pipeline frozen.
// Reset: synchronous, clears all valid bits and loads the identity matrix.
module homogeneous_vertex_transform #(
  parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = hvt_pkg::FRAC_BITS_DEF,
  localparam int IN_TD_W    = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TD_W   = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // x, y, z, w from bit 0 up, zero padded
  input  logic [IN_TD_W-1:0]             s_axis_tdata,
  // is_point
  input  logic                           s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // out_x, out_y, out_z from bit 0 up, zero padded
  output logic [OUT_TD_W-1:0]            m_axis_tdata,
  // out_w, zero_length, saturated from bit 0 up
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hvt_pkg::REG_W-1:0]      cfg_data
);
  import hvt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = ELEM_W + CW;      // one product
  localparam int SW    = PW + 2;           // sum of four products
  localparam int MAXSH = (CW > 32) ? CW - 32 : 0;
  localparam int DS    = (FRAC_BITS + 2) / 2;
  localparam int QE    = 2 * DS;
  localparam int SQ_SB = 3 * CW + 3 + 3 * MAG_W;   // res, sat, point, zero, mags
  localparam int DV_SB = 3 * CW + 3;               // res, sat, point, zero
  localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [63:0]   CL_HI  = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0]   CL_LO  = -(64'sd1 <<< (CW - 1));

  // ---------------------------------------------------------------- config
  logic [REG_W-1:0] mat [6];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= RST_ROW0_A;
      mat[1] <= RST_ROW0_B;
      mat[2] <= RST_ROW1_A;
      mat[3] <= RST_ROW1_B;
      mat[4] <= RST_ROW2_A;
      mat[5] <= RST_ROW2_B;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0_A: mat[0] <= cfg_data;
        REG_ROW0_B: mat[1] <= cfg_data;
        REG_ROW1_A: mat[2] <= cfg_data;
        REG_ROW1_B: mat[3] <= cfg_data;
        REG_ROW2_A: mat[4] <= cfg_data;
        REG_ROW2_B: mat[5] <= cfg_data;
        default: ;   // writes past the last register are dropped
      endcase
    end
  end

  // element (r, c): high half for even columns, low half for odd
  logic signed [ELEM_W-1:0] elem [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      elem[r][0] = mat[2*r][63:32];
      elem[r][1] = mat[2*r][31:0];
      elem[r][2] = mat[2*r+1][63:32];
      elem[r][3] = mat[2*r+1][31:0];
    end
  end

  // ------------------------------------------------------------ flow control
  logic en;          // global advance, low only while the skid slot is full
  logic in_acc;
  logic o_v, k_v;
  logic take;

  assign en            = !k_v;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign take          = m_axis_tvalid && m_axis_tready;

  // ------------------------------------------------ stage 1: products
  logic signed [CW-1:0] vin [4];
  logic signed [PW-1:0] p1 [3][4];
  logic                 v1, pt1;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vin[c] = s_axis_tdata[c*CW +: CW];
    end
  end

  // ------------------------------------------------ stage 2: rounded sums
  logic signed [SW-1:0] rs2 [3];
  logic                 v2, pt2;

  // ------------------------------------------------ stage 3: clamp, magnitude
  logic [2:0][CW-1:0]   res3;
  logic [2:0][CW-1:0]   mag3;
  logic                 v3, pt3, sat3;

  // ------------------------------------------------ stage 4: common shift
  logic [2:0][CW-1:0]    res4;
  logic [2:0][MAG_W-1:0] m4;
  logic                  v4, pt4, sat4;

  // ------------------------------------------------ stage 5: squares
  logic [2:0][CW-1:0]    res5;
  logic [2:0][MAG_W-1:0] m5;
  logic [63:0]           sq5 [3];
  logic                  v5, pt5, sat5;

  // ------------------------------------------------ stage 6: sum of squares
  logic [2:0][CW-1:0]    res6;
  logic [2:0][MAG_W-1:0] m6;
  logic [63:0]           s2_6;
  logic                  v6, pt6, sat6, zero6;

  logic signed [SW-1:0]  rs_next [3];
  logic [2:0][CW-1:0]    res_next;
  logic [2:0][CW-1:0]    mag_next;
  logic                  sat_next;
  logic [2:0][MAG_W-1:0] m_next;

  always_comb begin
    logic signed [SW-1:0] sum_t;
    logic [63:0]          maxm;
    int                   sh;
    // row sums, rounded to nearest with ties upward
    for (int r = 0; r < 3; r++) begin
      sum_t      = p1[r][0] + p1[r][1] + p1[r][2] + p1[r][3] + RND;
      rs_next[r] = sum_t >>> FRAC_BITS;
    end
    // saturate to the coordinate range
    sat_next = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (rs2[r] > SAT_HI) begin
        res_next[r] = SAT_HI[CW-1:0];
        sat_next    = 1'b1;
      end else if (rs2[r] < SAT_LO) begin
        res_next[r] = SAT_LO[CW-1:0];
        sat_next    = 1'b1;
      end else begin
        res_next[r] = rs2[r][CW-1:0];
      end
      mag_next[r] = res_next[r][CW-1] ? (~res_next[r] + CW'(1)) : res_next[r];
    end
    // smallest right shift bringing every magnitude to 2^31 or below
    maxm = 64'(mag3[0]);
    for (int r = 1; r < 3; r++) begin
      if (64'(mag3[r]) > maxm) maxm = 64'(mag3[r]);
    end
    sh = 0;
    for (int s = MAXSH; s >= 0; s--) begin
      if ((maxm >> s) <= (64'd1 << 31)) sh = s;
    end
    for (int r = 0; r < 3; r++) begin
      m_next[r] = MAG_W'(64'(mag3[r]) >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_acc;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          p1[r][c] <= elem[r][c] * vin[c];
        end
      end
      pt1 <= s_axis_tuser;
      for (int r = 0; r < 3; r++) rs2[r] <= rs_next[r];
      pt2  <= pt1;
      res3 <= res_next;
      mag3 <= mag_next;
      sat3 <= sat_next;
      pt3  <= pt2;
      res4 <= res3;
      m4   <= m_next;
      sat4 <= sat3;
      pt4  <= pt3;
      res5 <= res4;
      m5   <= m4;
      for (int r = 0; r < 3; r++) sq5[r] <= 64'(m4[r]) * 64'(m4[r]);
      sat5 <= sat4;
      pt5  <= pt4;
      res6  <= res5;
      m6    <= m5;
      s2_6  <= sq5[0] + sq5[1] + sq5[2];
      zero6 <= (sq5[0] | sq5[1] | sq5[2]) == 64'd0;
      sat6  <= sat5;
      pt6   <= pt5;
    end
  end

  // ------------------------------------------------ square root
  hvt_flow_t             sq_flow;
  logic                  sq_v;
  logic [ROOT_W-1:0]     sq_root;
  logic [SQ_SB-1:0]      sq_side;
  logic [2:0][CW-1:0]    sq_res;
  logic [2:0][MAG_W-1:0] sq_m;
  logic                  sq_sat, sq_pt, sq_zero;

  assign sq_flow = '{en: en, valid: v6};

  hvt_sqrt #(
    .SB (SQ_SB)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .flow      (sq_flow),
    .rad       (s2_6),
    .side_in   ({m6, zero6, pt6, sat6, res6}),
    .valid_out (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign {sq_m, sq_zero, sq_pt, sq_sat, sq_res} = sq_side;

  // ------------------------------------------------ divide
  hvt_flow_t          dv_flow;
  logic               dv_v;
  logic [2:0][QE-1:0] dv_q;
  logic [DV_SB-1:0]   dv_side;
  logic [2:0][CW-1:0] dv_res;
  logic               dv_sat, dv_pt, dv_zero;

  assign dv_flow = '{en: en, valid: sq_v};

  // zero length gives a zero root; divide by one and drop the quotient
  hvt_div #(
    .FRAC_BITS (FRAC_BITS),
    .SB        (DV_SB)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .flow      (dv_flow),
    .mag       (sq_m),
    .den       (sq_zero ? ROOT_W'(1) : sq_root),
    .side_in   ({sq_zero, sq_pt, sq_sat, sq_res}),
    .valid_out (dv_v),
    .quo       (dv_q),
    .side_out  (dv_side)
  );

  assign {dv_zero, dv_pt, dv_sat, dv_res} = dv_side;

  // ------------------------------------------------ result select
  logic [2:0][CW-1:0] f_xyz;
  logic               f_sat;
  logic [OUT_TD_W-1:0] f_data;
  logic [2:0]          f_user;

  always_comb begin
    logic signed [63:0] qs;
    f_sat = dv_sat;
    for (int l = 0; l < 3; l++) begin
      qs = $signed(64'(dv_q[l]));
      if (dv_res[l][CW-1]) qs = -qs;
      if (dv_pt) begin
        f_xyz[l] = dv_res[l];
      end else if (dv_zero) begin
        f_xyz[l] = '0;
      end else if (qs > CL_HI) begin
        f_xyz[l] = CL_HI[CW-1:0];
        f_sat    = 1'b1;
      end else if (qs < CL_LO) begin
        f_xyz[l] = CL_LO[CW-1:0];
        f_sat    = 1'b1;
      end else begin
        f_xyz[l] = qs[CW-1:0];
      end
    end
    f_data = OUT_TD_W'(f_xyz);
    f_user = {f_sat, dv_zero && !dv_pt, dv_pt};
  end

  // ------------------------------------------------ output and skid registers
  logic [OUT_TD_W-1:0] o_data, k_data;
  logic [2:0]          o_user, k_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      k_v <= 1'b0;
    end else if (k_v) begin
      if (take) k_v <= 1'b0;          // skid entry moves to output
    end else if (dv_v) begin
      if (!o_v || take) begin
        o_v <= 1'b1;
      end else begin
        k_v <= 1'b1;                  // output busy: park in skid
      end
    end else if (take) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (k_v && take) begin
      o_data <= k_data;
      o_user <= k_user;
    end else if (!k_v && dv_v && (!o_v || take)) begin
      o_data <= f_data;
      o_user <= f_user;
    end
    if (!k_v && dv_v && o_v && !take) begin
      k_data <= f_data;
      k_user <= f_user;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = o_data;
  assign m_axis_tuser  = o_user;

endmodule

[rtl/hvt_checker.sv]
// Port-level checks for the homogeneous vertex transform, and their bind.
// Depends on hvt_pkg and homogeneous_vertex_transform_macros.svh.
`include "homogeneous_vertex_transform_macros.svh"

module hvt_checker #(
  parameter int COORD_WIDTH = hvt_pkg::COORD_WIDTH_DEF,
  localparam int OUT_TD_W   = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic [OUT_TD_W-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready
);

  // a point never reports zero length
  `HVT_ASSERT_NOW(a_point_not_zero, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1])

  // zero length comes with all-zero components
  `HVT_ASSERT_NOW(a_zero_clears, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[3*COORD_WIDTH-1:0] == '0)

  // a stalled result is held
  `HVT_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind homogeneous_vertex_transform hvt_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_hvt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
